// File: hw/rtl/srtm_pkg.sv
// ----------------------------------------------------------------------------
// srtm_pkg: shared constants for the scale-rotate-translate matrix builder
// Field widths, CORDIC start value and the arctangent table in 2^-32 turn.
// ----------------------------------------------------------------------------
package srtm_pkg;

    localparam int SCALE_W          = 24;
    localparam int ANGLE_W          = 16;
    localparam int POS_W            = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int TRIG_ITER_DEF    = 16;
    localparam int TABLE_LEN        = 24;
    localparam int CORDIC_W         = 32;
    localparam int CORDIC_FRAC      = 30;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032875;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input int idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            default: v = 32'h00000051;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/srtm_cordic.sv
// ----------------------------------------------------------------------------
// srtm_cordic: pipelined CORDIC cosine/sine of a 16-bit binary angle
// One rotation step per register stage, then quadrant fix-up and rounding.
// ----------------------------------------------------------------------------
module srtm_cordic #(
    parameter int FRAC_BITS = srtm_pkg::FRAC_BITS_DEF,
    parameter int ITERS     = srtm_pkg::TRIG_ITER_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [srtm_pkg::ANGLE_W-1:0]         angle,
    output logic signed [FRAC_BITS+1:0]          cos_val,
    output logic signed [FRAC_BITS+1:0]          sin_val
);

    localparam int CW    = srtm_pkg::CORDIC_W;
    localparam int TW    = FRAC_BITS + 2;
    localparam int RSH   = srtm_pkg::CORDIC_FRAC - FRAC_BITS;
    localparam logic signed [CW-1:0] RND = CW'(1) <<< (RSH - 1);

    logic signed [CW-1:0] x_reg [ITERS];
    logic signed [CW-1:0] y_reg [ITERS];
    logic signed [CW-1:0] z_reg [ITERS];
    logic [1:0]           q_reg [ITERS];
    logic signed [TW-1:0] cos_reg;
    logic signed [TW-1:0] sin_reg;

    // quadrant and residual angle of the entering item
    logic [srtm_pkg::ANGLE_W-1:0] a_off;
    logic [1:0]                   q_in;
    logic [srtm_pkg::ANGLE_W-1:0] r_in;
    logic signed [CW-1:0]         z_in;

    always_comb
    begin
        a_off = angle + srtm_pkg::ANGLE_W'(8192);
        q_in  = a_off[srtm_pkg::ANGLE_W-1 -: 2];
        r_in  = angle - {q_in, {(srtm_pkg::ANGLE_W-2){1'b0}}};
        z_in  = CW'($signed(r_in)) <<< (CW - srtm_pkg::ANGLE_W);
    end

    // one rotation step per stage
    genvar i;
    generate
        for (i = 0; i < ITERS; i++)
        begin : g_step
            logic signed [CW-1:0] x_prev, y_prev, z_prev;
            logic [1:0]           q_prev;
            logic signed [CW-1:0] x_next, y_next, z_next;
            if (i == 0)
            begin : g_first
                assign x_prev = srtm_pkg::CORDIC_X0;
                assign y_prev = '0;
                assign z_prev = z_in;
                assign q_prev = q_in;
            end
            else
            begin : g_rest
                assign x_prev = x_reg[i-1];
                assign y_prev = y_reg[i-1];
                assign z_prev = z_reg[i-1];
                assign q_prev = q_reg[i-1];
            end
            always_comb
            begin
                if (!z_prev[CW-1])
                begin
                    x_next = x_prev - (y_prev >>> i);
                    y_next = y_prev + (x_prev >>> i);
                    z_next = z_prev - srtm_pkg::atan_turn(i);
                end
                else
                begin
                    x_next = x_prev + (y_prev >>> i);
                    y_next = y_prev - (x_prev >>> i);
                    z_next = z_prev + srtm_pkg::atan_turn(i);
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i] <= x_next;
                    y_reg[i] <= y_next;
                    z_reg[i] <= z_next;
                    q_reg[i] <= q_prev;
                end
            end
        end
    endgenerate

    // turn by the quadrant and round to the output format
    logic signed [CW-1:0] c_full, s_full, c_rnd, s_rnd;

    always_comb
    begin
        case (q_reg[ITERS-1])
            2'd0:    begin c_full = x_reg[ITERS-1];  s_full = y_reg[ITERS-1];  end
            2'd1:    begin c_full = -y_reg[ITERS-1]; s_full = x_reg[ITERS-1];  end
            2'd2:    begin c_full = -x_reg[ITERS-1]; s_full = -y_reg[ITERS-1]; end
            default: begin c_full = y_reg[ITERS-1];  s_full = -x_reg[ITERS-1]; end
        endcase
        c_rnd = (c_full + RND) >>> RSH;
        s_rnd = (s_full + RND) >>> RSH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= c_rnd[TW-1:0];
            sin_reg <= s_rnd[TW-1:0];
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// File: hw/rtl/scale_rotate_translate_matrix.sv
// ----------------------------------------------------------------------------
// scale_rotate_translate_matrix: model matrix builder
// Builds the eleven non-constant entries of a scale-rotate-translate matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries scales, two binary angles and a
//   position; output channel (out_valid/out_ready) carries the matrix entries.
//   Each transfer in yields exactly one transfer out, in order.
//   Path from input transfer to out_valid: one CORDIC step per stage, a
//   rounding stage, then two multiply stages, the last one being the
//   output register.
//   Throughput: one item per cycle unless stalled; both CORDIC pipelines
//   and the multipliers take a new item every cycle while not stalled.
//   Stall: when out_ready is low while a result is held, the whole pipeline
//   freezes and in_ready drops; nothing is lost or repeated. Empty slots
//   keep moving so in_ready stays high as long as the last stage is empty.
//   Reset: rst_n clears all valid bits; no result is pending afterwards.
//   Entries are signed fixed point with FRAC_BITS fraction bits, saturated to
//   24 bits; positions pass through unchanged.
// ----------------------------------------------------------------------------
module scale_rotate_translate_matrix #(
    parameter int FRAC_BITS       = srtm_pkg::FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = srtm_pkg::TRIG_ITER_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [srtm_pkg::SCALE_W-1:0]   scale_x,
    input  logic signed [srtm_pkg::SCALE_W-1:0]   scale_y,
    input  logic signed [srtm_pkg::SCALE_W-1:0]   scale_z,
    input  logic [srtm_pkg::ANGLE_W-1:0]          angle_about_y,
    input  logic [srtm_pkg::ANGLE_W-1:0]          angle_about_z,
    input  logic signed [srtm_pkg::POS_W-1:0]     pos_x,
    input  logic signed [srtm_pkg::POS_W-1:0]     pos_y,
    input  logic signed [srtm_pkg::POS_W-1:0]     pos_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [srtm_pkg::SCALE_W-1:0]   m_c0_r0,
    output logic signed [srtm_pkg::SCALE_W-1:0]   m_c1_r0,
    output logic signed [srtm_pkg::SCALE_W-1:0]   m_c2_r0,
    output logic signed [srtm_pkg::POS_W-1:0]     m_c3_r0,
    output logic signed [srtm_pkg::SCALE_W-1:0]   m_c0_r1,
    output logic signed [srtm_pkg::SCALE_W-1:0]   m_c1_r1,
    output logic signed [srtm_pkg::POS_W-1:0]     m_c3_r1,
    output logic signed [srtm_pkg::SCALE_W-1:0]   m_c0_r2,
    output logic signed [srtm_pkg::SCALE_W-1:0]   m_c1_r2,
    output logic signed [srtm_pkg::SCALE_W-1:0]   m_c2_r2,
    output logic signed [srtm_pkg::POS_W-1:0]     m_c3_r2
);

    localparam int N   = (TRIG_ITERATIONS < srtm_pkg::TABLE_LEN) ?
                         TRIG_ITERATIONS : srtm_pkg::TABLE_LEN;
    localparam int SW  = srtm_pkg::SCALE_W;
    localparam int PSW = srtm_pkg::POS_W;
    localparam int IW  = SW + 2;
    localparam int TW  = FRAC_BITS + 2;
    localparam int PW  = IW + TW;
    localparam int L   = N + 3;
    localparam logic signed [PW-1:0] SAT_MAX = PW'((64'sd1 <<< (SW-1)) - 1);
    localparam logic signed [PW-1:0] SAT_MIN = -(PW'(64'sd1 <<< (SW-1)));

    function automatic logic signed [PW-1:0] mul_rnd(
        input logic signed [IW-1:0] a,
        input logic signed [TW-1:0] b
    );
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        p = p + (PW'(1) <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [SW-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[SW-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[SW-1:0];
        else
            r = v[SW-1:0];
        return r;
    endfunction

    // global advance: move unless a result waits at the output
    logic         en;
    logic [L-1:0] vld_reg;

    assign en       = !vld_reg[L-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[L-2:0], in_valid};
    end

    // sine and cosine of both angles
    logic signed [TW-1:0] cy, sny, cz, snz;

    srtm_cordic #(.FRAC_BITS(FRAC_BITS), .ITERS(N)) u_trig_y (
        .clk     (clk),
        .en      (en),
        .angle   (angle_about_y),
        .cos_val (cy),
        .sin_val (sny)
    );

    srtm_cordic #(.FRAC_BITS(FRAC_BITS), .ITERS(N)) u_trig_z (
        .clk     (clk),
        .en      (en),
        .angle   (angle_about_z),
        .cos_val (cz),
        .sin_val (snz)
    );

    // delay scales and positions alongside the CORDIC stages
    logic signed [SW-1:0]  sx_reg [N+1];
    logic signed [SW-1:0]  sy_reg [N+1];
    logic signed [SW-1:0]  sz_reg [N+1];
    logic signed [PSW-1:0] px_reg [N+1];
    logic signed [PSW-1:0] py_reg [N+1];
    logic signed [PSW-1:0] pz_reg [N+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg[0] <= scale_x;
            sy_reg[0] <= scale_y;
            sz_reg[0] <= scale_z;
            px_reg[0] <= pos_x;
            py_reg[0] <= pos_y;
            pz_reg[0] <= pos_z;
            for (int k = 1; k <= N; k++)
            begin
                sx_reg[k] <= sx_reg[k-1];
                sy_reg[k] <= sy_reg[k-1];
                sz_reg[k] <= sz_reg[k-1];
                px_reg[k] <= px_reg[k-1];
                py_reg[k] <= py_reg[k-1];
                pz_reg[k] <= pz_reg[k-1];
            end
        end
    end

    // first products
    logic signed [IW-1:0] sx_w, sy_w, sz_w;
    logic signed [PW-1:0] p0_next, p1_next, p7_next, p8_next;
    logic signed [IW-1:0] p0_reg, p1_reg, p7_reg, p8_reg;
    logic signed [SW-1:0] e2_reg, e4_reg, e5_reg, e9_reg;
    logic signed [TW-1:0] cz_reg, snz_reg;
    logic signed [PSW-1:0] qx_reg, qy_reg, qz_reg;

    always_comb
    begin
        sx_w    = IW'(sx_reg[N]);
        sy_w    = IW'(sy_reg[N]);
        sz_w    = IW'(sz_reg[N]);
        p0_next = mul_rnd(sx_w, cy);
        p1_next = mul_rnd(-sy_w, cy);
        p7_next = mul_rnd(-sx_w, sny);
        p8_next = mul_rnd(sy_w, sny);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next[IW-1:0];
            p1_reg  <= p1_next[IW-1:0];
            p7_reg  <= p7_next[IW-1:0];
            p8_reg  <= p8_next[IW-1:0];
            e2_reg  <= sat(mul_rnd(sz_w, sny));
            e4_reg  <= sat(mul_rnd(sx_w, snz));
            e5_reg  <= sat(mul_rnd(sy_w, cz));
            e9_reg  <= sat(mul_rnd(sz_w, cy));
            cz_reg  <= cz;
            snz_reg <= snz;
            qx_reg  <= px_reg[N];
            qy_reg  <= py_reg[N];
            qz_reg  <= pz_reg[N];
        end
    end

    // second products and output register
    logic signed [SW-1:0]  o0_reg, o1_reg, o2_reg, o4_reg, o5_reg;
    logic signed [SW-1:0]  o7_reg, o8_reg, o9_reg;
    logic signed [PSW-1:0] o3_reg, o6_reg, o10_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o0_reg  <= sat(mul_rnd(p0_reg, cz_reg));
            o1_reg  <= sat(mul_rnd(p1_reg, snz_reg));
            o7_reg  <= sat(mul_rnd(p7_reg, cz_reg));
            o8_reg  <= sat(mul_rnd(p8_reg, snz_reg));
            o2_reg  <= e2_reg;
            o4_reg  <= e4_reg;
            o5_reg  <= e5_reg;
            o9_reg  <= e9_reg;
            o3_reg  <= qx_reg;
            o6_reg  <= qy_reg;
            o10_reg <= qz_reg;
        end
    end

    assign out_valid = vld_reg[L-1];
    assign m_c0_r0   = o0_reg;
    assign m_c1_r0   = o1_reg;
    assign m_c2_r0   = o2_reg;
    assign m_c3_r0   = o3_reg;
    assign m_c0_r1   = o4_reg;
    assign m_c1_r1   = o5_reg;
    assign m_c3_r1   = o6_reg;
    assign m_c0_r2   = o7_reg;
    assign m_c1_r2   = o8_reg;
    assign m_c2_r2   = o9_reg;
    assign m_c3_r2   = o10_reg;

endmodule

// File: hw/rtl/srtm_checker.sv
// ----------------------------------------------------------------------------
// srtm_checker: port-level checks for the matrix builder
// Watches the handshakes on the top level and flags flow-control slips.
// ----------------------------------------------------------------------------
module srtm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [srtm_pkg::POS_W-1:0]   m_c3_r0
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(m_c3_r0))
        else $error("output transfer dropped or changed while stalled");

    // accept input whenever the output side drains
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // accept input whenever no result is held
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // come out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result pending right after reset");

endmodule

bind scale_rotate_translate_matrix srtm_checker u_srtm_checker (.*);
